// ===== hw/rtl/rk_pkg.sv =====
// Shared types, constants and the microprogram of the Roessler RK4 integrator.
package rk_pkg;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_DONE} state_t;

	typedef enum logic [2:0] {UK_KX, UK_MAC, UK_ACC, UK_FIN, UK_END} ukind_t;
	typedef enum logic [2:0] {A_AY, A_AZ, A_KX, A_KY, A_KZ, A_SX, A_SY, A_SZ} asel_t;
	typedef enum logic [1:0] {B_MU, B_AXM, B_DT} bsel_t;
	typedef enum logic [1:0] {R_Q24, R_Q25, R_FIN} rnd_t;
	typedef enum logic [2:0] {D_AX, D_C04, D_X, D_Y, D_Z, D_ZERO} addsel_t;
	typedef enum logic [2:0] {W_KY, W_KZ, W_AX, W_AY, W_AZ, W_X, W_Y, W_Z} dst_t;

	typedef struct packed {
		ukind_t  kind;
		asel_t   asel;
		bsel_t   bsel;
		rnd_t    rnd;
		addsel_t add;
		dst_t    dst;
		logic    dbl;
	} uop_t;

	typedef struct packed {
		logic              ovf;
		logic signed [31:0] val;
	} sat_t;

	typedef struct packed {
		logic [6:0] q;
		logic [2:0] r;
	} dig_t;

	typedef enum logic {REG_MU = 1'b0, REG_DT = 1'b1} reg_t;

	localparam logic [31:0] DT_RESET = 32'd838861;
	localparam logic signed [32:0] C04 = 33'sd6710886;
	localparam logic signed [32:0] C85 = 33'sd142606336;
	// 6 * 2^31: bias that makes the final quotient non-negative
	localparam logic signed [43:0] FIN_BIAS = 44'sd12884901888;
	localparam logic [34:0] FIN_TOP = 35'd25769803775;

	function automatic sat_t sat32(input logic signed [44:0] v);
		sat_t s;
		if (v > 45'sd2147483647) begin
			s.ovf = 1'b1;
			s.val = 32'sh7fffffff;
		end else if (v < -45'sd2147483648) begin
			s.ovf = 1'b1;
			s.val = 32'sh80000000;
		end else begin
			s.ovf = 1'b0;
			s.val = v[31:0];
		end
		return s;
	endfunction

	// t < 768: quotient and remainder by six through a reciprocal
	function automatic dig_t div6(input logic [9:0] t);
		dig_t d;
		logic [19:0] p;
		logic [9:0] back;
		p = 20'(t) * 20'd683;
		d.q = p[18:12];
		back = 10'(t - ({3'b0, d.q} << 2) - ({3'b0, d.q} << 1));
		d.r = back[2:0];
		return d;
	endfunction

	function automatic uop_t u_simple(input ukind_t k, input logic dbl);
		uop_t u;
		u = '{kind: k, asel: A_AY, bsel: B_MU, rnd: R_Q24, add: D_ZERO, dst: W_KY, dbl: dbl};
		return u;
	endfunction

	function automatic uop_t u_mac(input asel_t a, input bsel_t b, input rnd_t r,
			input addsel_t ad, input dst_t d);
		uop_t u;
		u = '{kind: UK_MAC, asel: a, bsel: b, rnd: r, add: ad, dst: d, dbl: 1'b0};
		return u;
	endfunction

	function automatic uop_t u_fin(input asel_t a, input dst_t d);
		uop_t u;
		u = '{kind: UK_FIN, asel: a, bsel: B_DT, rnd: R_FIN, add: D_ZERO, dst: d, dbl: 1'b0};
		return u;
	endfunction

	function automatic uop_t uop_at(input logic [4:0] pc);
		uop_t u;
		unique case (pc) inside
			5'd0, 5'd7, 5'd14, 5'd21: u = u_simple(UK_KX, 1'b0);
			5'd1, 5'd8, 5'd15, 5'd22: u = u_mac(A_AY, B_MU, R_Q24, D_AX, W_KY);
			5'd2, 5'd9, 5'd16, 5'd23: u = u_mac(A_AZ, B_AXM, R_Q24, D_C04, W_KZ);
			5'd3, 5'd24:              u = u_simple(UK_ACC, 1'b0);
			5'd10, 5'd17:             u = u_simple(UK_ACC, 1'b1);
			5'd4, 5'd11:  u = u_mac(A_KX, B_DT, R_Q25, D_X, W_AX);
			5'd5, 5'd12:  u = u_mac(A_KY, B_DT, R_Q25, D_Y, W_AY);
			5'd6, 5'd13:  u = u_mac(A_KZ, B_DT, R_Q25, D_Z, W_AZ);
			5'd18:        u = u_mac(A_KX, B_DT, R_Q24, D_X, W_AX);
			5'd19:        u = u_mac(A_KY, B_DT, R_Q24, D_Y, W_AY);
			5'd20:        u = u_mac(A_KZ, B_DT, R_Q24, D_Z, W_AZ);
			5'd25:        u = u_fin(A_SX, W_X);
			5'd26:        u = u_fin(A_SY, W_Y);
			5'd27:        u = u_fin(A_SZ, W_Z);
			default:      u = u_simple(UK_END, 1'b0);
		endcase
		return u;
	endfunction

endpackage

// ===== hw/rtl/rk_if.sv =====
// Request and result channel interfaces of the integrator.
interface rk_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [31:0] load_x;
	logic signed [31:0] load_y;
	logic signed [31:0] load_z;
	modport source(output valid, mode, load_x, load_y, load_z, input ready);
	modport sink(input valid, mode, load_x, load_y, load_z, output ready);
endinterface

interface rk_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               crossed;
	logic               saturated;
	modport source(output valid, pos_x, pos_y, pos_z, crossed, saturated, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, crossed, saturated, output ready);
endinterface

// ===== hw/rtl/rk_regs.sv =====
// APB configuration registers: coupling mu and time step.
module rk_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic signed [31:0] mu,
	output logic [24:0]        dt
);
	logic signed [31:0] mu_q;
	logic [24:0]        dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= '0;
			dt_q <= rk_pkg::DT_RESET[24:0];
		end else if (psel && penable && pwrite) begin
			unique case (rk_pkg::reg_t'(paddr[2]))
				rk_pkg::REG_MU: mu_q <= pwdata;
				rk_pkg::REG_DT: dt_q <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (rk_pkg::reg_t'(paddr[2]))
			rk_pkg::REG_MU: prdata = mu_q;
			rk_pkg::REG_DT: prdata = {7'b0, dt_q};
			default:        prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign mu     = mu_q;
	assign dt     = dt_q;
endmodule

// ===== hw/rtl/rk_mac.sv =====
// Shared multiplier with rounding shift, addend and saturation.
module rk_mac (
	input  logic               clk,
	input  logic signed [34:0] a,
	input  logic signed [32:0] b,
	input  rk_pkg::rnd_t       rnd,
	input  logic signed [32:0] addend,
	output rk_pkg::sat_t       res,
	output logic [34:0]        fin_u,
	output logic               fin_ovf
);
	logic signed [67:0] prod_d;
	logic signed [67:0] prod_q;
	logic signed [67:0] rc;
	logic signed [67:0] biased;
	logic signed [67:0] shifted;
	logic signed [43:0] q;
	logic signed [44:0] sum;

	assign prod_d = a * b;

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	always_comb begin
		case (rnd)
			rk_pkg::R_Q25: rc = 68'sd16777216;
			rk_pkg::R_FIN: rc = 68'sd50331648;
			default:       rc = 68'sd8388608;
		endcase
		biased  = prod_q + rc;
		shifted = (rnd == rk_pkg::R_Q25) ? (biased >>> 25) : (biased >>> 24);
		q       = shifted[43:0];
		sum     = {q[43], q} + {{12{addend[32]}}, addend};
		res     = rk_pkg::sat32(sum);
		// final increment: clamp so that the quotient by six saturates
		if (q >= rk_pkg::FIN_BIAS) begin
			fin_u   = rk_pkg::FIN_TOP;
			fin_ovf = 1'b1;
		end else if (q < -rk_pkg::FIN_BIAS) begin
			fin_u   = '0;
			fin_ovf = 1'b1;
		end else begin
			fin_u   = 35'(q + rk_pkg::FIN_BIAS);
			fin_ovf = 1'b0;
		end
	end
endmodule

// ===== hw/rtl/rk_div6.sv =====
// Digit-serial division by six, seven quotient bits a cycle.
module rk_div6 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [34:0] u,
	output logic        busy,
	output logic        done,
	output logic [31:0] quo
);
	logic [34:0] num_q;
	logic [34:0] quo_q;
	logic [2:0]  rem_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	rk_pkg::dig_t dig;

	assign dig = rk_pkg::div6({rem_q, num_q[34:28]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= u;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[27:0], 7'b0};
			rem_q <= dig.r;
			quo_q <= {quo_q[27:0], dig.q};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q[31:0];
endmodule

// ===== hw/rtl/roessler_rk4_integrator_top.sv =====
// Top level: sequencer, state registers and result register of the RK4 integrator.
//
// Requests arrive on in_ch (valid/ready). mode 0 loads x, y and z from the
// request; mode 1 advances the Roessler system by one RK4 step of length dt.
// Each request gives exactly one result on out_ch: position, a flag for a
// downward zero crossing of x and a flag for any saturation in the step.
// A load passes from idle through the done state into the result register; a step
// runs the microprogram through twenty products in the one shared multiplier and
// three digit-serial divisions by six in the final update, then the done state.
// in_ch.ready is high only while the sequencer is idle: one request at a time.
// The result register holds the last result until out_ch.ready takes it; a
// new request is accepted meanwhile, and the sequencer waits at its end if
// that register is still full.
// Configuration over APB: mu at address 0, dt at address 4; write only while
// idle. Reset clears x, y, z, the crossing history and sets mu = 0, dt = 0.05.
module roessler_rk4_integrator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rk_in_if.sink       in_ch,
	rk_out_if.source    out_ch
);
	logic signed [31:0] mu;
	logic [24:0]        dt;

	rk_pkg::state_t state_q, state_d;
	logic [4:0]  pc_q;
	logic        phase_q;
	logic        is_step_q;
	logic        sat_q;
	logic        prev_pos_q;
	logic        ovalid_q;
	rk_pkg::uop_t uop;

	logic signed [31:0] x_q, y_q, z_q;
	logic signed [31:0] ax_q, ay_q, az_q;
	logic signed [31:0] kx_q, ky_q, kz_q;
	logic signed [34:0] sx_q, sy_q, sz_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic               ocross_q, osat_q;

	logic accept, push, pc_adv, mac_wr, div_start, fin_wr;
	logic signed [34:0] mac_a;
	logic signed [32:0] mac_b;
	logic signed [32:0] mac_add;
	rk_pkg::sat_t mac_res;
	logic [34:0]  fin_u;
	logic         fin_ovf;
	logic         div_busy, div_done;
	logic [31:0]  quo;
	logic signed [33:0] nk;
	rk_pkg::sat_t kx_res;
	logic signed [31:0] fin_v;
	logic signed [31:0] inc;
	rk_pkg::sat_t fin_res;
	logic signed [34:0] acc_x, acc_y, acc_z;

	rk_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mu(mu), .dt(dt)
	);

	rk_mac u_mac (
		.clk(clk), .a(mac_a), .b(mac_b), .rnd(uop.rnd), .addend(mac_add),
		.res(mac_res), .fin_u(fin_u), .fin_ovf(fin_ovf)
	);

	rk_div6 u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .u(fin_u),
		.busy(div_busy), .done(div_done), .quo(quo)
	);

	assign uop = rk_pkg::uop_at(pc_q);

	// operand selection for the shared unit
	always_comb begin
		case (uop.asel)
			rk_pkg::A_AY: mac_a = {{3{ay_q[31]}}, ay_q};
			rk_pkg::A_AZ: mac_a = {{3{az_q[31]}}, az_q};
			rk_pkg::A_KX: mac_a = {{3{kx_q[31]}}, kx_q};
			rk_pkg::A_KY: mac_a = {{3{ky_q[31]}}, ky_q};
			rk_pkg::A_KZ: mac_a = {{3{kz_q[31]}}, kz_q};
			rk_pkg::A_SX: mac_a = sx_q;
			rk_pkg::A_SY: mac_a = sy_q;
			default:      mac_a = sz_q;
		endcase
		case (uop.bsel)
			rk_pkg::B_MU:  mac_b = {mu[31], mu};
			rk_pkg::B_AXM: mac_b = {ax_q[31], ax_q} - rk_pkg::C85;
			default:       mac_b = {8'b0, dt};
		endcase
		case (uop.add)
			rk_pkg::D_AX:  mac_add = {ax_q[31], ax_q};
			rk_pkg::D_C04: mac_add = rk_pkg::C04;
			rk_pkg::D_X:   mac_add = {x_q[31], x_q};
			rk_pkg::D_Y:   mac_add = {y_q[31], y_q};
			rk_pkg::D_Z:   mac_add = {z_q[31], z_q};
			default:       mac_add = '0;
		endcase
	end

	// dx = -y - z, needs no product
	always_comb begin
		nk     = 34'sd0 - {{2{ay_q[31]}}, ay_q} - {{2{az_q[31]}}, az_q};
		kx_res = rk_pkg::sat32({{11{nk[33]}}, nk});
		acc_x  = uop.dbl ? {{2{kx_q[31]}}, kx_q, 1'b0} : {{3{kx_q[31]}}, kx_q};
		acc_y  = uop.dbl ? {{2{ky_q[31]}}, ky_q, 1'b0} : {{3{ky_q[31]}}, ky_q};
		acc_z  = uop.dbl ? {{2{kz_q[31]}}, kz_q, 1'b0} : {{3{kz_q[31]}}, kz_q};
		case (uop.dst)
			rk_pkg::W_X: fin_v = x_q;
			rk_pkg::W_Y: fin_v = y_q;
			default:     fin_v = z_q;
		endcase
		inc     = {~quo[31], quo[30:0]};
		fin_res = rk_pkg::sat32({{13{fin_v[31]}}, fin_v} + {{13{inc[31]}}, inc});
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rk_pkg::ST_IDLE: if (in_ch.valid) state_d = in_ch.mode ? rk_pkg::ST_RUN : rk_pkg::ST_DONE;
			rk_pkg::ST_RUN: begin
				if (uop.kind == rk_pkg::UK_END) state_d = rk_pkg::ST_DONE;
				else if (uop.kind == rk_pkg::UK_FIN && phase_q) state_d = rk_pkg::ST_DIV;
			end
			rk_pkg::ST_DIV:  if (div_done) state_d = rk_pkg::ST_RUN;
			rk_pkg::ST_DONE: if (!ovalid_q || out_ch.ready) state_d = rk_pkg::ST_IDLE;
			default:         state_d = rk_pkg::ST_IDLE;
		endcase
	end

	// control decode
	always_comb begin
		accept    = 1'b0;
		push      = 1'b0;
		pc_adv    = 1'b0;
		mac_wr    = 1'b0;
		div_start = 1'b0;
		fin_wr    = 1'b0;
		unique case (state_q)
			rk_pkg::ST_IDLE: accept = in_ch.valid;
			rk_pkg::ST_RUN: begin
				case (uop.kind) inside
					rk_pkg::UK_KX, rk_pkg::UK_ACC: pc_adv = 1'b1;
					rk_pkg::UK_MAC: begin
						pc_adv = phase_q;
						mac_wr = phase_q;
					end
					rk_pkg::UK_FIN: div_start = phase_q;
					default: ;
				endcase
			end
			rk_pkg::ST_DIV: begin
				fin_wr = div_done;
				pc_adv = div_done;
			end
			rk_pkg::ST_DONE: push = !ovalid_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rk_pkg::ST_IDLE;
			pc_q       <= '0;
			phase_q    <= 1'b0;
			is_step_q  <= 1'b0;
			sat_q      <= 1'b0;
			prev_pos_q <= 1'b0;
			ovalid_q   <= 1'b0;
			x_q        <= '0;
			y_q        <= '0;
			z_q        <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= (state_q == rk_pkg::ST_RUN) &&
				(uop.kind == rk_pkg::UK_MAC || uop.kind == rk_pkg::UK_FIN) && !phase_q;
			if (accept) begin
				pc_q      <= '0;
				is_step_q <= in_ch.mode;
				sat_q     <= 1'b0;
				if (!in_ch.mode) begin
					x_q <= in_ch.load_x;
					y_q <= in_ch.load_y;
					z_q <= in_ch.load_z;
				end
			end else if (pc_adv) begin
				pc_q <= pc_q + 5'd1;
			end
			if (state_q == rk_pkg::ST_RUN && uop.kind == rk_pkg::UK_KX && kx_res.ovf)
				sat_q <= 1'b1;
			if (mac_wr && mac_res.ovf) sat_q <= 1'b1;
			if (div_start && fin_ovf) sat_q <= 1'b1;
			if (fin_wr) begin
				if (fin_res.ovf) sat_q <= 1'b1;
				case (uop.dst)
					rk_pkg::W_X: x_q <= fin_res.val;
					rk_pkg::W_Y: y_q <= fin_res.val;
					default:     z_q <= fin_res.val;
				endcase
			end
			if (push) begin
				ovalid_q   <= 1'b1;
				prev_pos_q <= is_step_q && !x_q[31] && (x_q != 32'sd0);
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// working registers of the step
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= x_q;
			ay_q <= y_q;
			az_q <= z_q;
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
		end
		if (state_q == rk_pkg::ST_RUN && uop.kind == rk_pkg::UK_KX) kx_q <= kx_res.val;
		if (state_q == rk_pkg::ST_RUN && uop.kind == rk_pkg::UK_ACC) begin
			sx_q <= sx_q + acc_x;
			sy_q <= sy_q + acc_y;
			sz_q <= sz_q + acc_z;
		end
		if (mac_wr) begin
			case (uop.dst)
				rk_pkg::W_KY: ky_q <= mac_res.val;
				rk_pkg::W_KZ: kz_q <= mac_res.val;
				rk_pkg::W_AX: ax_q <= mac_res.val;
				rk_pkg::W_AY: ay_q <= mac_res.val;
				default:      az_q <= mac_res.val;
			endcase
		end
		if (push) begin
			ox_q     <= x_q;
			oy_q     <= y_q;
			oz_q     <= z_q;
			ocross_q <= is_step_q && prev_pos_q && x_q[31];
			osat_q   <= sat_q;
		end
	end

	assign in_ch.ready      = (state_q == rk_pkg::ST_IDLE);
	assign out_ch.valid     = ovalid_q;
	assign out_ch.pos_x     = ox_q;
	assign out_ch.pos_y     = oy_q;
	assign out_ch.pos_z     = oz_q;
	assign out_ch.crossed   = ocross_q;
	assign out_ch.saturated = osat_q;

`ifndef ASSERT_OFF
	a_div_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rk_pkg::ST_DIV) |-> (uop.kind == rk_pkg::UK_FIN))
		else $error("divide wait outside a final update");
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rk_pkg::ST_IDLE) |-> !div_busy)
		else $error("divider busy while idle");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_ch.mode) |=> (state_q == rk_pkg::ST_DONE))
		else $error("load request not finished at once");
	a_cross_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.crossed) |-> out_ch.pos_x[31])
		else $error("crossing flagged with non-negative x");
`endif
endmodule

// ===== sim/tb_roessler_rk4_integrator_top.sv =====
// Self-checking testbench for the Roessler RK4 integrator top level.
module tb_roessler_rk4_integrator_top;

	typedef struct {
		bit      mode;
		int      lx;
		int      ly;
		int      lz;
	} request_t;

	typedef struct {
		int      px;
		int      py;
		int      pz;
		bit      crossed;
		bit      saturated;
	} position_t;

	localparam longint ONE_Q = 64'sd16777216;
	localparam longint HALF_DEN = 64'sd33554432;
	localparam longint K04 = 64'sd6710886;
	localparam longint K85 = 64'sd142606336;
	localparam longint ATT_R = 64'sd251658240;	// 15.0

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rk_in_if  in_ch();
	rk_out_if out_ch();

	roessler_rk4_integrator_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	request_t  pending_reqs[$];
	position_t expected_pos[$];
	int        mismatches = 0;
	bit        no_idle = 0;

	// model state
	longint mu_m, dt_m, sx, sy, sz, prev_x;
	bit     clamp_hit;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			clamp_hit = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clamp_hit = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// floor(n/den + 1/2)
	function automatic longint round_div(longint n, longint den);
		longint m;
		m = n + den / 2;
		if (m >= 0)
			return m / den;
		return -((-m + den - 1) / den);
	endfunction

	function automatic longint deriv_x(longint y, longint z);
		return clamp32(-y - z);
	endfunction

	function automatic longint deriv_y(longint x, longint y);
		return clamp32(x + round_div(mu_m * y, ONE_Q));
	endfunction

	function automatic longint deriv_z(longint x, longint z);
		return clamp32(K04 + round_div(z * (x - K85), ONE_Q));
	endfunction

	function automatic longint advance(longint v, longint k, longint den);
		return clamp32(v + round_div(k * dt_m, den));
	endfunction

	function automatic longint combine(longint v, longint k1, longint k2, longint k3,
			longint k4);
		longint s;
		s = k1 + 2 * k2 + 2 * k3 + k4;
		return clamp32(v + clamp32(round_div(s * dt_m, 6 * ONE_Q)));
	endfunction

	function automatic position_t rk4_predict(request_t r);
		position_t p;
		longint x, y, z, kx1, ky1, kz1, kx2, ky2, kz2, kx3, ky3, kz3, kx4, ky4, kz4;
		longint xa, ya, za, xb, yb, zb, xc, yc, zc;
		clamp_hit = 0;
		p.crossed = 0;
		if (!r.mode) begin
			sx = r.lx;
			sy = r.ly;
			sz = r.lz;
			prev_x = 0;
		end else begin
			x = sx; y = sy; z = sz;
			kx1 = deriv_x(y, z); ky1 = deriv_y(x, y); kz1 = deriv_z(x, z);
			xa = advance(x, kx1, HALF_DEN); ya = advance(y, ky1, HALF_DEN);
			za = advance(z, kz1, HALF_DEN);
			kx2 = deriv_x(ya, za); ky2 = deriv_y(xa, ya); kz2 = deriv_z(xa, za);
			xb = advance(x, kx2, HALF_DEN); yb = advance(y, ky2, HALF_DEN);
			zb = advance(z, kz2, HALF_DEN);
			kx3 = deriv_x(yb, zb); ky3 = deriv_y(xb, yb); kz3 = deriv_z(xb, zb);
			xc = advance(x, kx3, ONE_Q); yc = advance(y, ky3, ONE_Q);
			zc = advance(z, kz3, ONE_Q);
			kx4 = deriv_x(yc, zc); ky4 = deriv_y(xc, yc); kz4 = deriv_z(xc, zc);
			sx = combine(x, kx1, kx2, kx3, kx4);
			sy = combine(y, ky1, ky2, ky3, ky4);
			sz = combine(z, kz1, kz2, kz3, kz4);
			p.crossed = (prev_x > 0) && (sx < 0);
			prev_x = sx;
		end
		p.px = int'(sx);
		p.py = int'(sy);
		p.pz = int'(sz);
		p.saturated = clamp_hit;
		return p;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		bit       drive;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_pos.push_back(rk4_predict('{in_ch.mode, in_ch.load_x,
					in_ch.load_y, in_ch.load_z}));
			if (!in_ch.valid || in_ch.ready) begin
				drive = pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 14);
				if (drive) begin
					r = pending_reqs.pop_front();
					in_ch.mode <= r.mode;
					in_ch.load_x <= r.lx;
					in_ch.load_y <= r.ly;
					in_ch.load_z <= r.lz;
				end
				in_ch.valid <= drive;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		position_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pos.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result x=%0d y=%0d z=%0d", out_ch.pos_x,
							out_ch.pos_y, out_ch.pos_z);
				end else begin
					e = expected_pos.pop_front();
					if (out_ch.pos_x !== e.px || out_ch.pos_y !== e.py ||
							out_ch.pos_z !== e.pz || out_ch.crossed !== e.crossed ||
							out_ch.saturated !== e.saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%0d y=%0d z=%0d c=%0b s=%0b, got x=%0d y=%0d z=%0d c=%0b s=%0b",
								e.px, e.py, e.pz, e.crossed, e.saturated,
								out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
								out_ch.crossed, out_ch.saturated);
					end
				end
			end
			out_ch.ready <= no_idle || $urandom_range(0, 99) >= 14;
		end
	end

	task automatic add_load(int x, int y, int z);
		pending_reqs.push_back('{1'b0, x, y, z});
	endtask

	task automatic add_steps(int n);
		repeat (n) pending_reqs.push_back('{1'b1, $urandom, $urandom, $urandom});
	endtask

	function automatic int near_attractor();
		return int'(longint'($urandom_range(0, 2 * ATT_R)) - ATT_R);
	endfunction

	// hold the sender until every request has been answered
	task automatic drain();
		while (pending_reqs.size() > 0 || in_ch.valid || expected_pos.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic reg_write(rk_pkg::reg_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == rk_pkg::REG_MU)
			mu_m = longint'(signed'(v));
		else
			dt_m = longint'(v & 32'h1ffffff);
	endtask

	task automatic random_phase(int n_items);
		int left;
		int n;
		left = n_items;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0)
				add_load($urandom, $urandom, $urandom);
			else
				add_load(near_attractor(), near_attractor(), near_attractor() / 2);
			n = $urandom_range(3, 40);
			add_steps(n);
			left -= n + 1;
		end
	endtask

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_ch.valid = 0; in_ch.mode = 0;
		in_ch.load_x = 0; in_ch.load_y = 0; in_ch.load_z = 0;
		out_ch.ready = 0;
		mu_m = 0; dt_m = rk_pkg::DT_RESET; sx = 0; sy = 0; sz = 0; prev_x = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset state, defaults
		add_steps(2);
		add_load(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		add_steps(2);
		add_load(32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_steps(2);
		add_load(int'(ONE_Q), int'(ONE_Q), int'(ONE_Q));
		add_steps(6);
		drain();
		reg_write(rk_pkg::REG_MU, 32'd3355443);	// 0.2
		reg_write(rk_pkg::REG_DT, 32'd16777216);	// dt = 1.0
		add_load(int'(ONE_Q), 0, 0);
		add_steps(3);
		add_load(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		add_steps(1);
		drain();
		reg_write(rk_pkg::REG_DT, 32'h1ffffff);	// beyond nominal range
		add_load(int'(ONE_Q), -int'(ONE_Q), 0);
		add_steps(2);
		drain();

		reg_write(rk_pkg::REG_DT, 32'd838861);
		random_phase(300);
		drain();
		reg_write(rk_pkg::REG_DT, 32'd0);
		reg_write(rk_pkg::REG_MU, 32'h80000000);
		random_phase(60);
		drain();
		reg_write(rk_pkg::REG_MU, 32'h7fffffff);
		reg_write(rk_pkg::REG_DT, 32'd167772);
		random_phase(60);
		drain();
		reg_write(rk_pkg::REG_MU, 32'd3355443);
		reg_write(rk_pkg::REG_DT, 32'd1677722);
		no_idle = 1;
		random_phase(150);
		drain();
		no_idle = 0;
		reg_write(rk_pkg::REG_MU, $urandom);
		reg_write(rk_pkg::REG_DT, $urandom_range(0, 2 * 1677722));
		random_phase(200);
		drain();
		reg_write(rk_pkg::REG_MU, $urandom_range(0, 8388608));
		reg_write(rk_pkg::REG_DT, $urandom_range(0, 33554431));
		random_phase(250);
		drain();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== roessler_rk4_integrator_top.f =====
hw/rtl/rk_pkg.sv
hw/rtl/rk_if.sv
hw/rtl/rk_regs.sv
hw/rtl/rk_mac.sv
hw/rtl/rk_div6.sv
hw/rtl/roessler_rk4_integrator_top.sv
sim/tb_roessler_rk4_integrator_top.sv
